[design/ps2mq_pkg.sv]
// ============================================================================
// PS/2 mouse packet queue package
// Shared sizes, status byte bit positions and the event record layout.
// ============================================================================
`default_nettype none

package ps2mq_pkg;

    // Ring queue size. The queue holds at most QUEUE_DEPTH-1 events.
    localparam int QUEUE_DEPTH = 32;
    localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    // Field widths.
    localparam int BYTE_W = 8;
    localparam int DX_W   = 9;
    localparam int DY_W   = 10;
    localparam int BTN_W  = 3;

    // Bit positions in the status byte.
    localparam int SYNC_BIT  = 3;
    localparam int XSIGN_BIT = 4;
    localparam int YSIGN_BIT = 5;

    // Command codes.
    localparam logic CMD_RX_BYTE = 1'b0;
    localparam logic CMD_POLL    = 1'b1;

    // One decoded mouse event, packed as stored in the queue:
    // delta_x in bits 8:0, delta_y in bits 18:9, buttons in bits 21:19.
    typedef struct packed {
        logic [BTN_W-1:0] buttons;
        logic [DY_W-1:0]  delta_y;
        logic [DX_W-1:0]  delta_x;
    } event_t;

    // Next ring index with wrap at the queue depth.
    function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] ptr);
        logic [PTR_W-1:0] nxt;
        if (ptr == PTR_W'(QUEUE_DEPTH - 1)) begin
            nxt = '0;
        end else begin
            nxt = ptr + PTR_W'(1);
        end
        return nxt;
    endfunction

endpackage

`default_nettype wire

[design/ps2_mouse_packet_queue.sv]
// A poll beat is held in the input register, and its result is loaded from there
// into the output register. Throughput: one beat per cycle. A poll waits in the
// input register while a result beat is held, so s_ready then follows m_ready.
// Bytes give no result. Reset clears the packet state, the queue pointers and
// both valid flags; queue storage is not cleared.
// ============================================================================
// PS/2 mouse packet queue
// Decodes 3-byte PS/2 mouse packets into events, queues them and returns
// the oldest event for each poll beat.
// ============================================================================
`default_nettype none

module ps2_mouse_packet_queue (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // Input channel
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic                                s_command,
    input  wire logic [ps2mq_pkg::BYTE_W-1:0]        s_rx_byte,
    // Result channel
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic                                     m_event_found,
    output logic signed [ps2mq_pkg::DX_W-1:0]        m_delta_x,
    output logic signed [ps2mq_pkg::DY_W-1:0]        m_delta_y,
    output logic [ps2mq_pkg::BTN_W-1:0]              m_buttons
);

    logic                          in_valid_reg;
    logic                          in_cmd_reg;
    logic [ps2mq_pkg::BYTE_W-1:0]  in_byte_reg;
    logic                          out_valid_reg, out_valid_next;
    logic                          found_reg;
    logic                          out_free;
    logic                          fire;
    logic                          is_poll;
    logic                          byte_fire;
    logic                          poll_fire;
    logic                          evt_valid;
    logic                          empty;
    ps2mq_pkg::event_t             evt;
    ps2mq_pkg::event_t             pop_evt;

    // A byte beat always completes; a poll beat needs room in the result register.
    assign out_free  = !out_valid_reg || m_ready;
    assign is_poll   = (in_cmd_reg == ps2mq_pkg::CMD_POLL);
    assign fire      = in_valid_reg && (!is_poll || out_free);
    assign byte_fire = fire && !is_poll;
    assign poll_fire = fire && is_poll;
    assign s_ready   = !in_valid_reg || fire;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_cmd_reg  <= s_command;
            in_byte_reg <= s_rx_byte;
        end
    end

    ps2mq_packet_decode u_decode (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .byte_valid (byte_fire),
        .byte_data  (in_byte_reg),
        .evt_valid  (evt_valid),
        .evt        (evt)
    );

    ps2mq_event_ring u_ring (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (evt_valid),
        .push_evt (evt),
        .pop      (poll_fire),
        .empty    (empty),
        .pop_evt  (pop_evt)
    );

    // Result register valid flag.
    always_comb begin
        out_valid_next = out_valid_reg;
        if (m_ready) begin
            out_valid_next = 1'b0;
        end
        if (poll_fire) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (poll_fire) begin
            found_reg <= !empty;
        end
    end

    // Result beat; an empty poll returns zero fields.
    assign m_valid       = out_valid_reg;
    assign m_event_found = found_reg;
    assign m_delta_x     = found_reg ? $signed(pop_evt.delta_x) : '0;
    assign m_delta_y     = found_reg ? $signed(pop_evt.delta_y) : '0;
    assign m_buttons     = found_reg ? pop_evt.buttons : '0;

endmodule

`default_nettype wire

[design/ps2mq_packet_decode.sv]
// ============================================================================
// PS/2 mouse packet decoder
// Gathers status, X and Y bytes into a packet and forms one event on the
// cycle the Y byte is taken. Keeps packet alignment through the sync bit.
// ============================================================================
`default_nettype none

module ps2mq_packet_decode (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         byte_valid,
    input  wire logic [ps2mq_pkg::BYTE_W-1:0] byte_data,
    output logic                              evt_valid,
    output ps2mq_pkg::event_t                 evt
);

    // Position of the next byte in the packet.
    localparam logic [1:0] POS_STATUS = 2'd0;
    localparam logic [1:0] POS_X      = 2'd1;
    localparam logic [1:0] POS_Y      = 2'd2;

    logic [1:0]                    pos_reg,    pos_next;
    logic [ps2mq_pkg::BYTE_W-1:0]  status_reg, status_next;
    logic [ps2mq_pkg::BYTE_W-1:0]  x_reg,      x_next;
    logic [ps2mq_pkg::DY_W-1:0]    y_ext;

    // Packet assembly. A status byte without the sync bit is dropped.
    always_comb begin
        pos_next    = pos_reg;
        status_next = status_reg;
        x_next      = x_reg;
        evt_valid   = 1'b0;
        if (byte_valid) begin
            case (pos_reg)
                POS_STATUS: begin
                    if (byte_data[ps2mq_pkg::SYNC_BIT]) begin
                        status_next = byte_data;
                        pos_next    = POS_X;
                    end
                end
                POS_X: begin
                    x_next   = byte_data;
                    pos_next = POS_Y;
                end
                POS_Y: begin
                    pos_next  = POS_STATUS;
                    evt_valid = 1'b1;
                end
                default: begin
                    pos_next = POS_STATUS;
                end
            endcase
        end
    end

    // Event fields. The sign bit joined above the byte gives value - 256
    // when set; Y is negated so that down on the screen is positive.
    assign y_ext = {status_reg[ps2mq_pkg::YSIGN_BIT], status_reg[ps2mq_pkg::YSIGN_BIT],
                    byte_data};

    always_comb begin
        evt.delta_x = {status_reg[ps2mq_pkg::XSIGN_BIT], x_reg};
        evt.delta_y = ps2mq_pkg::DY_W'(0) - y_ext;
        evt.buttons = status_reg[ps2mq_pkg::BTN_W-1:0];
    end

    // Packet state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= POS_STATUS;
            status_reg <= '0;
            x_reg      <= '0;
        end else begin
            pos_reg    <= pos_next;
            status_reg <= status_next;
            x_reg      <= x_next;
        end
    end

endmodule

`default_nettype wire

[design/ps2mq_top_queue_note.sv]
// ============================================================================
// PS/2 mouse event ring queue
// Ring buffer of decoded events with one write port and one registered read.
// ============================================================================
`default_nettype none

module ps2mq_event_ring (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          push,
    input  wire ps2mq_pkg::event_t             push_evt,
    input  wire logic                          pop,
    output logic                               empty,
    output ps2mq_pkg::event_t                  pop_evt
);

    ps2mq_pkg::event_t              mem [ps2mq_pkg::QUEUE_DEPTH];
    logic [ps2mq_pkg::PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [ps2mq_pkg::PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic                           full;

    // Occupancy. One slot stays unused so that full and empty differ.
    assign empty = (rd_ptr_reg == wr_ptr_reg);
    assign full  = (ps2mq_pkg::ring_next(wr_ptr_reg) == rd_ptr_reg);

    // Pointer updates. A push into a full queue is dropped.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push && !full) begin
            wr_ptr_next = ps2mq_pkg::ring_next(wr_ptr_reg);
        end
        if (pop && !empty) begin
            rd_ptr_next = ps2mq_pkg::ring_next(rd_ptr_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    // Storage write port.
    always_ff @(posedge aclk) begin
        if (push && !full) begin
            mem[wr_ptr_reg] <= push_evt;
        end
    end

    // Registered read; the data holds until the next pop.
    always_ff @(posedge aclk) begin
        if (pop) begin
            pop_evt <= mem[rd_ptr_reg];
        end
    end

endmodule

`default_nettype wire
